// ===== rtl/odw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package odw_pkg;
    typedef logic [2:0] t_status;
    localparam t_status ST_APPEND  = 3'd0;
    localparam t_status ST_REPLACE = 3'd1;
    localparam t_status ST_INSERT  = 3'd2;
    localparam t_status ST_DROPPED = 3'd3;
    localparam t_status ST_READ    = 3'd4;
    localparam t_status ST_EMPTY   = 3'd5;
    localparam int STAMP_BITS = 64;
    localparam int COUNT_OUT_BITS = 6;
endpackage
`default_nettype wire

// ===== rtl/ordered_dedup_window_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// per-bucket window of records kept sorted by signed stamp, held as a ring in one
// shared ram with a head slot and count per bucket, so dropping the oldest costs no
// copy. requests queue in a two-entry fifo ahead of a sequencer that does one request
// at a time through the single ram read and write port: an append or replace of the
// newest reads the last record and compares stamps, an in-order insert scans up to
// the slot, then shifts each later record up one slot, and a read emits the records
// one by one, oldest first. no clearing pass.
module ordered_dedup_window_store #(
    parameter int DEPTH = 32,
    parameter int NUM_BUCKETS = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_op,
    input  wire logic [3:0]              i_bucket,
    input  wire logic signed [63:0]      i_stamp,
    input  wire logic [PAYLOAD_BITS-1:0] i_payload,
    input  wire logic                    i_cfg_we,
    input  wire logic [5:0]              i_cfg_data,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [2:0]                   o_status,
    output logic signed [63:0]           o_out_stamp,
    output logic [PAYLOAD_BITS-1:0]      o_out_payload,
    output logic [5:0]                   o_count_after,
    output logic                         o_last
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int QW = 1 + BW + 64 + PAYLOAD_BITS;

    typedef logic [15:0][7:0] t_wrap;

    function automatic t_wrap mk_wrap();
        t_wrap t;
        for (int v = 0; v < 16; v++) t[v] = 8'(v % NUM_BUCKETS);
        return t;
    endfunction

    localparam t_wrap WRAP = mk_wrap();

    logic [5:0]    r_capacity;
    logic [CW-1:0] eff_cap;
    logic [BW-1:0] bkt;
    logic [QW-1:0] q_in, q_out;
    logic          q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 6'd32;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_capacity == 6'd0) eff_cap = CW'(1);
        else if (int'(r_capacity) > DEPTH) eff_cap = CW'(DEPTH);
        else eff_cap = CW'(r_capacity);
    end

    assign bkt  = BW'(WRAP[i_bucket]);
    assign q_in = {i_op, bkt, i_stamp, i_payload};

    odw_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(q_in), .o_valid(q_valid), .i_ready(q_ready), .o_data(q_out)
    );

    odw_engine #(.DEPTH(DEPTH), .NUM_BUCKETS(NUM_BUCKETS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item_valid(q_valid), .o_item_ready(q_ready),
        .i_op(q_out[QW-1]), .i_bucket(q_out[QW-2 -: BW]),
        .i_stamp(q_out[PAYLOAD_BITS +: 64]), .i_payload(q_out[PAYLOAD_BITS-1:0]),
        .i_cap(eff_cap),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_stamp(o_out_stamp), .o_payload(o_out_payload),
        .o_count(o_count_after), .o_last(o_last)
    );
endmodule
`default_nettype wire

// ===== rtl/odw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module odw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// ===== rtl/odw_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module odw_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic      [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = i_rst_n && (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/odw_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module odw_engine #(
    parameter int DEPTH = 32,
    parameter int NUM_BUCKETS = 16,
    parameter int PAYLOAD_BITS = 64,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_item_valid,
    output logic                         o_item_ready,
    input  wire logic                    i_op,
    input  wire logic [BW-1:0]           i_bucket,
    input  wire logic signed [63:0]      i_stamp,
    input  wire logic [PAYLOAD_BITS-1:0] i_payload,
    input  wire logic [CW-1:0]           i_cap,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output odw_pkg::t_status             o_status,
    output logic signed [63:0]           o_stamp,
    output logic [PAYLOAD_BITS-1:0]      o_payload,
    output logic [odw_pkg::COUNT_OUT_BITS-1:0] o_count,
    output logic                         o_last
);
    localparam int RDEPTH = NUM_BUCKETS * DEPTH;
    localparam int AW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int RW = odw_pkg::STAMP_BITS + PAYLOAD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RD_ISSUE, S_RD_DATA, S_UP_LAST, S_SCAN, S_SHIFT, S_PUT, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic                    r_op, n_op;
    logic [BW-1:0]           r_bkt, n_bkt;
    logic signed [63:0]      r_s, n_s;
    logic [PAYLOAD_BITS-1:0] r_p, n_p;
    logic [CW-1:0]           r_cap, n_cap;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [HW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_pos, n_pos;
    odw_pkg::t_status        r_st, n_st;
    logic [CW-1:0]           r_cnts [NUM_BUCKETS];
    logic [HW-1:0]           r_heads [NUM_BUCKETS];
    logic                    r_ov, n_ov;
    odw_pkg::t_status        r_ost, n_ost;
    logic signed [63:0]      r_ostamp, n_ostamp;
    logic [PAYLOAD_BITS-1:0] r_opay, n_opay;
    logic [CW-1:0]           r_ocnt, n_ocnt;
    logic                    r_olast, n_olast;
    logic                    wb_en;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, rdata;
    logic signed [63:0] d_stamp;
    logic          out_free;
    logic [CW:0]   cnt_p1, drop_ins, drop_tr;

    function automatic logic [HW-1:0] slot(input logic [HW-1:0] h, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(h) + (CW + 1)'(off);
        if (s >= (CW + 1)'(DEPTH)) s = s - (CW + 1)'(DEPTH);
        return HW'(s);
    endfunction

    function automatic logic [AW-1:0] addr(input logic [BW-1:0] b, input logic [HW-1:0] sl);
        return AW'(int'(b) * DEPTH + int'(sl));
    endfunction

    odw_ram #(.WIDTH(RW), .DEPTH(RDEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rdata)
    );

    assign d_stamp  = rdata[RW-1:PAYLOAD_BITS];
    assign out_free = !r_ov || i_ready;
    assign cnt_p1   = (CW + 1)'(r_cnt) + (CW + 1)'(1);
    assign drop_ins = (cnt_p1 > (CW + 1)'(r_cap)) ? cnt_p1 - (CW + 1)'(r_cap) : '0;
    assign drop_tr  = ((CW + 1)'(r_cnt) > (CW + 1)'(r_cap))
                    ? (CW + 1)'(r_cnt) - (CW + 1)'(r_cap) : '0;

    assign o_item_ready = (r_state == S_IDLE);
    assign o_valid   = r_ov;
    assign o_status  = r_ost;
    assign o_stamp   = r_ostamp;
    assign o_payload = r_opay;
    assign o_count   = odw_pkg::COUNT_OUT_BITS'(r_ocnt);
    assign o_last    = r_olast;

    always_comb begin
        n_state = r_state; n_op = r_op; n_bkt = r_bkt; n_s = r_s; n_p = r_p;
        n_cap = r_cap; n_cnt = r_cnt; n_head = r_head; n_idx = r_idx; n_pos = r_pos;
        n_st = r_st; n_ov = r_ov && !i_ready; n_ost = r_ost; n_ostamp = r_ostamp;
        n_opay = r_opay; n_ocnt = r_ocnt; n_olast = r_olast; wb_en = 1'b0;
        we = 1'b0; waddr = addr(r_bkt, slot(r_head, r_idx)); wdata = {r_s, r_p};
        re = 1'b0; raddr = addr(r_bkt, slot(r_head, r_idx));
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_op = i_op; n_bkt = i_bucket; n_s = i_stamp; n_p = i_payload;
                    n_cap = i_cap; n_cnt = r_cnts[i_bucket]; n_head = r_heads[i_bucket];
                    n_state = S_START;
                end
            end
            S_START: begin
                n_idx = '0;
                if (r_op) begin
                    if (r_cnt == '0) begin
                        n_st = odw_pkg::ST_EMPTY;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_RD_ISSUE;
                    end
                end else if (r_cnt == '0) begin
                    we = 1'b1;
                    waddr = addr(r_bkt, r_head);
                    n_cnt = CW'(1);
                    n_st = odw_pkg::ST_APPEND;
                    n_state = S_EMIT;
                end else begin
                    re = 1'b1;
                    raddr = addr(r_bkt, slot(r_head, r_cnt - CW'(1)));
                    n_state = S_UP_LAST;
                end
            end
            S_RD_ISSUE: begin
                re = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (out_free) begin
                    n_ov = 1'b1; n_ost = odw_pkg::ST_READ;
                    n_ostamp = d_stamp; n_opay = rdata[PAYLOAD_BITS-1:0];
                    n_ocnt = r_cnt; n_olast = (r_idx == r_cnt - CW'(1));
                    if (n_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_state = S_RD_ISSUE;
                    end
                end
            end
            S_UP_LAST: begin
                if (d_stamp == r_s) begin
                    we = 1'b1;
                    waddr = addr(r_bkt, slot(r_head, r_cnt - CW'(1)));
                    n_st = odw_pkg::ST_REPLACE;
                    n_state = S_EMIT;
                end else if (!(r_s < d_stamp)) begin
                    we = 1'b1;
                    waddr = addr(r_bkt, slot(r_head, r_cnt));
                    n_head = slot(r_head, CW'(drop_ins));
                    n_cnt = CW'(cnt_p1 - drop_ins);
                    n_st = odw_pkg::ST_APPEND;
                    n_state = S_EMIT;
                end else begin
                    re = 1'b1;
                    raddr = addr(r_bkt, r_head);
                    n_idx = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (d_stamp < r_s) begin
                    n_idx = r_idx + CW'(1);
                    re = 1'b1;
                    raddr = addr(r_bkt, slot(r_head, n_idx));
                end else if (d_stamp == r_s) begin
                    we = 1'b1;
                    n_head = slot(r_head, CW'(drop_tr));
                    n_cnt = CW'((CW + 1)'(r_cnt) - drop_tr);
                    n_st = odw_pkg::ST_REPLACE;
                    n_state = S_EMIT;
                end else if ((CW + 1)'(r_idx) < drop_ins) begin
                    n_head = slot(r_head, CW'(drop_tr));
                    n_cnt = CW'((CW + 1)'(r_cnt) - drop_tr);
                    n_st = odw_pkg::ST_DROPPED;
                    n_state = S_EMIT;
                end else begin
                    n_pos = r_idx;
                    n_idx = r_cnt - CW'(1);
                    re = 1'b1;
                    raddr = addr(r_bkt, slot(r_head, n_idx));
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                we = 1'b1;
                waddr = addr(r_bkt, slot(r_head, r_idx + CW'(1)));
                wdata = rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    n_idx = r_idx - CW'(1);
                    re = 1'b1;
                    raddr = addr(r_bkt, slot(r_head, n_idx));
                end
            end
            S_PUT: begin
                we = 1'b1;
                waddr = addr(r_bkt, slot(r_head, r_pos));
                n_head = slot(r_head, CW'(drop_ins));
                n_cnt = CW'(cnt_p1 - drop_ins);
                n_st = odw_pkg::ST_INSERT;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_ost = r_st; n_ostamp = '0; n_opay = '0;
                    n_ocnt = r_cnt; n_olast = 1'b1; wb_en = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_bkt <= n_bkt; r_s <= n_s; r_p <= n_p; r_cap <= n_cap;
        r_cnt <= n_cnt; r_head <= n_head; r_idx <= n_idx; r_pos <= n_pos; r_st <= n_st;
        r_ost <= n_ost; r_ostamp <= n_ostamp; r_opay <= n_opay; r_ocnt <= n_ocnt;
        r_olast <= n_olast;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            for (int k = 0; k < NUM_BUCKETS; k++) begin
                r_cnts[k]  <= '0;
                r_heads[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
            if (wb_en) begin
                r_cnts[r_bkt]  <= r_cnt;
                r_heads[r_bkt] <= r_head;
            end
        end
    end
endmodule
`default_nettype wire
